>>> rtl/taqe_pkg.sv
// ---------------------------------------------------------------------------
// taqe_pkg
// Shared field widths and codes of the tree ancestor query engine.
// ---------------------------------------------------------------------------
`default_nettype none

package taqe_pkg;

    localparam int OP_W     = 2;
    localparam int FIELD_W  = 10;
    localparam int DIST_W   = 11;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 11;
    localparam int IN_W     = 32;
    localparam int OUT_W    = 40;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam op_t OP_ADD   = 2'd0;
    localparam op_t OP_BUILD = 2'd1;
    localparam op_t OP_QUERY = 2'd2;
    localparam op_t OP_NOP   = 2'd3;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_RANGE    = 2'd1;
    localparam status_t ST_FULL     = 2'd2;
    localparam status_t ST_NOTBUILT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 1'b1;

endpackage

`default_nettype wire

>>> rtl/taqe_ram.sv
// ---------------------------------------------------------------------------
// taqe_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module taqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/tree_ancestor_query_engine_unit.sv
// ---------------------------------------------------------------------------
// tree_ancestor_query_engine_unit
// Lowest common ancestor engine built on a binary-lifting ancestor table.
// ---------------------------------------------------------------------------
// Input requests arrive on s_tvalid/s_tready/s_tdata and each produces one
// result on m_tvalid/m_tready/m_tdata. A request is taken only while the
// engine is idle; a finished result sits in the output register, so the next
// request is taken while that result still waits for m_tready. A stalled
// receiver holds the engine only when a second result is ready to leave.
// Configuration writes use cfg_valid/cfg_ready (always ready) and must be
// issued while no request is in flight.
// Add-edge and no-operation requests go from idle straight to the result
// state. A query reads the marks and depths of both nodes, climbs the deeper
// node hop by hop, runs the lifting search and then climbs once per set bit
// of steps; its table reads share the single read port of the ancestor
// table. A build clears the reached marks of all MAX_NODES nodes, walks the
// tree by scanning every stored edge for each reached node, then fills
// LEVELS-1 table levels node by node.
// Reset (rst_n low, asynchronous) empties the edge store, marks the tables as
// not built and restores root_node 0 and node_count 1024.
// ---------------------------------------------------------------------------
`default_nettype none

module tree_ancestor_query_engine_unit #(
    parameter int MAX_NODES = 1024,
    parameter int LEVELS    = 11
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // operation[1:0], node_a[11:2], node_b[21:12], steps[31:22]
    input  wire logic [taqe_pkg::IN_W-1:0]          s_tdata,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // status[1:0], common_ancestor[11:2], distance[22:12], ancestor[32:23],
    // ancestor_found[33], zero fill above
    output logic      [taqe_pkg::OUT_W-1:0]         m_tdata,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [taqe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [taqe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    import taqe_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int TEW = NW + 1;
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int LW  = $clog2(LEVELS);
    localparam int TD  = MAX_NODES * LEVELS;
    localparam int TAW = $clog2(TD);
    localparam int EAW = $clog2(MAX_NODES - 1);
    localparam logic [TEW-1:0] NO_NODE = TEW'(MAX_NODES);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_DONE  = 5'd1;
    localparam logic [4:0] B_CLR   = 5'd2;
    localparam logic [4:0] B_ROOT  = 5'd3;
    localparam logic [4:0] B_POP   = 5'd4;
    localparam logic [4:0] B_PWT   = 5'd5;
    localparam logic [4:0] B_PDP   = 5'd6;
    localparam logic [4:0] B_ERD   = 5'd7;
    localparam logic [4:0] B_ECK   = 5'd8;
    localparam logic [4:0] B_EMK   = 5'd9;
    localparam logic [4:0] L_RD    = 5'd10;
    localparam logic [4:0] L_P     = 5'd11;
    localparam logic [4:0] L_W     = 5'd12;
    localparam logic [4:0] Q_MA    = 5'd13;
    localparam logic [4:0] Q_MB    = 5'd14;
    localparam logic [4:0] Q_MC    = 5'd15;
    localparam logic [4:0] Q_DA    = 5'd16;
    localparam logic [4:0] Q_DB    = 5'd17;
    localparam logic [4:0] Q_UP    = 5'd18;
    localparam logic [4:0] Q_UPW   = 5'd19;
    localparam logic [4:0] Q_HA    = 5'd20;
    localparam logic [4:0] Q_HB    = 5'd21;
    localparam logic [4:0] Q_HC    = 5'd22;
    localparam logic [4:0] Q_LCA   = 5'd23;
    localparam logic [4:0] Q_LD    = 5'd24;
    localparam logic [4:0] Q_LDW   = 5'd25;
    localparam logic [4:0] Q_CL    = 5'd26;
    localparam logic [4:0] Q_CW    = 5'd27;

    function automatic logic [TAW-1:0] taddr(input logic [NW-1:0] n,
                                             input logic [LW-1:0] l);
        taddr = TAW'(n) * TAW'(LEVELS) + TAW'(l);
    endfunction

    // Control state.
    logic [4:0]       state_reg, state_next;
    logic [FIELD_W-1:0] root_node_reg;
    logic [COUNT_W-1:0] node_count_reg;
    logic [NW-1:0]    edge_total_reg, edge_total_next;
    logic             built_reg, built_next;
    logic [NW:0]      sp_reg, sp_next;
    logic             out_valid_reg, out_valid_next;

    // Working registers.
    logic [NW-1:0]    e_reg, e_next;
    logic [NW-1:0]    j_reg, j_next;
    logic [LW-1:0]    i_reg, i_next;
    logic [LW-1:0]    lvl_reg, lvl_next;
    logic [NW-1:0]    cur_reg, cur_next;
    logic [NW-1:0]    cur_dep_reg, cur_dep_next;
    logic [NW-1:0]    nb_reg, nb_next;
    logic [NW-1:0]    a_reg, a_next;
    logic [NW-1:0]    b_reg, b_next;
    logic [9:0]       k_reg, k_next;
    logic [NW-1:0]    qa_reg, qa_next;
    logic [NW-1:0]    qb_reg, qb_next;
    logic [NW-1:0]    da_reg, da_next;
    logic [NW-1:0]    db_reg, db_next;
    logic [NW-1:0]    diff_reg, diff_next;
    logic [TEW-1:0]   ha_reg, ha_next;
    logic             ma_reg, ma_next;
    logic [NW-1:0]    lca_reg, lca_next;
    logic [NW-1:0]    ca_reg, ca_next;
    status_t          res_status_reg, res_status_next;
    logic [DIST_W-1:0] res_dist_reg, res_dist_next;
    logic             res_found_reg, res_found_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;

    // Memory ports.
    logic             edge_we, mark_we, mark_wdata, dep_we, stk_we, tab_we;
    logic [NW-1:0]    edge_waddr, edge_raddr;
    logic [2*NW-1:0]  edge_wdata, edge_rdata;
    logic [NW-1:0]    mark_waddr, mark_raddr;
    logic             mark_rdata;
    logic [NW-1:0]    dep_waddr, dep_raddr, dep_wdata, dep_rdata;
    logic [NW-1:0]    stk_waddr, stk_raddr, stk_wdata, stk_rdata;
    logic [TAW-1:0]   tab_waddr, tab_raddr;
    logic [TEW-1:0]   tab_wdata, tab_rdata;

    // Decoded request and helpers.
    op_t              in_op;
    logic [NW-1:0]    in_a, in_b;
    logic [CW-1:0]    cnt;
    logic             in_range;
    logic [NW-1:0]    ex, ey, nb_c;
    logic             hit_c;
    logic [LW-1:0]    up_lvl;
    logic             edge_last, lift_last;
    logic             unmarked;
    logic [NW:0]      dist_c;

    assign in_op = s_tdata[1:0];
    assign in_a  = NW'(s_tdata[11:2]);
    assign in_b  = NW'(s_tdata[21:12]);
    assign cnt   = (32'(node_count_reg) > 32'(MAX_NODES)) ? CW'(MAX_NODES)
                                                           : CW'(node_count_reg);
    assign in_range = (32'(s_tdata[11:2]) < 32'(cnt)) &&
                      (32'(s_tdata[21:12]) < 32'(cnt));

    assign ex = edge_rdata[NW-1:0];
    assign ey = edge_rdata[2*NW-1:NW];
    assign hit_c = (ex == cur_reg) || (ey == cur_reg);
    assign nb_c  = (ex == cur_reg) ? ey : ex;
    assign edge_last = (32'(e_reg) + 32'd1) >= 32'(edge_total_reg);
    assign lift_last = (32'(j_reg) + 32'd1) >= 32'(cnt);
    assign unmarked  = !mark_rdata;
    assign dist_c = {1'b0, da_reg} + {1'b0, db_reg} - ({1'b0, dep_rdata} << 1);

    always_comb
    begin
        up_lvl = '0;
        for (int n = 0; n < NW; n++)
        begin
            if (diff_reg[n] && n < LEVELS - 1)
            begin
                up_lvl = LW'(n);
            end
        end
        if ((32'(diff_reg) >> (LEVELS - 1)) != 32'd0)
        begin
            up_lvl = LW'(LEVELS - 1);
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Memory port steering.
    always_comb
    begin
        edge_we = 1'b0;
        edge_waddr = edge_total_reg;
        edge_wdata = {in_b, in_a};
        edge_raddr = e_reg;
        mark_we = 1'b0;
        mark_waddr = nb_reg;
        mark_wdata = 1'b1;
        mark_raddr = nb_c;
        dep_we = 1'b0;
        dep_waddr = nb_reg;
        dep_wdata = cur_dep_reg + NW'(1);
        dep_raddr = stk_rdata;
        stk_we = 1'b0;
        stk_waddr = NW'(sp_reg);
        stk_wdata = nb_reg;
        stk_raddr = NW'(sp_reg - (NW+1)'(1));
        tab_we = 1'b0;
        tab_waddr = taddr(nb_reg, '0);
        tab_wdata = {1'b0, cur_reg};
        tab_raddr = taddr(qa_reg, lvl_reg);
        case (state_reg)
            S_IDLE:
            begin
                edge_we = s_tvalid && in_op == OP_ADD && in_range &&
                          32'(edge_total_reg) < 32'(MAX_NODES - 1);
            end
            B_CLR:
            begin
                mark_we = 1'b1;
                mark_waddr = j_reg;
                mark_wdata = 1'b0;
            end
            B_ROOT:
            begin
                mark_we = 1'b1;
                mark_waddr = NW'(root_node_reg);
                dep_we = 1'b1;
                dep_waddr = NW'(root_node_reg);
                dep_wdata = '0;
                stk_we = 1'b1;
                stk_waddr = '0;
                stk_wdata = NW'(root_node_reg);
                tab_we = 1'b1;
                tab_waddr = taddr(NW'(root_node_reg), '0);
                tab_wdata = NO_NODE;
            end
            B_EMK:
            begin
                mark_we = unmarked;
                dep_we = unmarked;
                stk_we = unmarked;
                tab_we = unmarked;
            end
            L_RD:
            begin
                tab_raddr = taddr(j_reg, i_reg - LW'(1));
            end
            L_P:
            begin
                tab_raddr = taddr(tab_rdata[NW-1:0], i_reg - LW'(1));
                tab_we = (tab_rdata == NO_NODE);
                tab_waddr = taddr(j_reg, i_reg);
                tab_wdata = NO_NODE;
            end
            L_W:
            begin
                tab_we = 1'b1;
                tab_waddr = taddr(j_reg, i_reg);
                tab_wdata = tab_rdata;
            end
            Q_MA:
            begin
                mark_raddr = a_reg;
            end
            Q_MB:
            begin
                mark_raddr = b_reg;
            end
            Q_MC:
            begin
                dep_raddr = a_reg;
            end
            Q_DA:
            begin
                dep_raddr = b_reg;
            end
            Q_UP:
            begin
                tab_raddr = taddr(qa_reg, up_lvl);
            end
            Q_HB:
            begin
                tab_raddr = taddr(qb_reg, lvl_reg);
            end
            Q_HC:
            begin
                tab_raddr = taddr(qa_reg, '0);
            end
            Q_LD:
            begin
                dep_raddr = lca_reg;
            end
            Q_CL:
            begin
                tab_raddr = taddr(ca_reg, lvl_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        edge_total_next = edge_total_reg;
        built_next = built_reg;
        sp_next = sp_reg;
        out_valid_next = out_valid_reg;
        e_next = e_reg;
        j_next = j_reg;
        i_next = i_reg;
        lvl_next = lvl_reg;
        cur_next = cur_reg;
        cur_dep_next = cur_dep_reg;
        nb_next = nb_reg;
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        qa_next = qa_reg;
        qb_next = qb_reg;
        da_next = da_reg;
        db_next = db_reg;
        diff_next = diff_reg;
        ha_next = ha_reg;
        ma_next = ma_reg;
        lca_next = lca_reg;
        ca_next = ca_reg;
        res_status_next = res_status_reg;
        res_dist_next = res_dist_reg;
        res_found_next = res_found_reg;
        out_data_next = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    a_next = in_a;
                    b_next = in_b;
                    k_next = s_tdata[31:22];
                    res_status_next = ST_OK;
                    res_dist_next = '0;
                    res_found_next = 1'b0;
                    lca_next = '0;
                    ca_next = '0;
                    state_next = S_DONE;
                    case (in_op)
                        OP_ADD:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (32'(edge_total_reg) >= 32'(MAX_NODES - 1))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else
                            begin
                                edge_total_next = edge_total_reg + NW'(1);
                                built_next = 1'b0;
                            end
                        end
                        OP_BUILD:
                        begin
                            built_next = 1'b0;
                            if (32'(root_node_reg) >= 32'(cnt))
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                j_next = '0;
                                state_next = B_CLR;
                            end
                        end
                        OP_QUERY:
                        begin
                            if (!in_range)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else if (!built_reg)
                            begin
                                res_status_next = ST_NOTBUILT;
                            end
                            else
                            begin
                                state_next = Q_MA;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {6'b0, res_found_reg, 10'(ca_reg), res_dist_reg,
                                     10'(lca_reg), res_status_reg};
                    state_next = S_IDLE;
                end
            end
            B_CLR:
            begin
                j_next = j_reg + NW'(1);
                if (32'(j_reg) == 32'(MAX_NODES - 1))
                begin
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                sp_next = (NW+1)'(1);
                state_next = B_POP;
            end
            B_POP:
            begin
                if (sp_reg == '0)
                begin
                    i_next = LW'(1);
                    j_next = '0;
                    state_next = L_RD;
                end
                else
                begin
                    sp_next = sp_reg - (NW+1)'(1);
                    state_next = B_PWT;
                end
            end
            B_PWT:
            begin
                cur_next = stk_rdata;
                state_next = B_PDP;
            end
            B_PDP:
            begin
                cur_dep_next = dep_rdata;
                e_next = '0;
                state_next = (edge_total_reg == '0) ? B_POP : B_ERD;
            end
            B_ERD:
            begin
                state_next = B_ECK;
            end
            B_ECK:
            begin
                nb_next = nb_c;
                if (hit_c && 32'(nb_c) < 32'(cnt))
                begin
                    state_next = B_EMK;
                end
                else
                begin
                    e_next = e_reg + NW'(1);
                    state_next = edge_last ? B_POP : B_ERD;
                end
            end
            B_EMK:
            begin
                if (unmarked)
                begin
                    sp_next = sp_reg + (NW+1)'(1);
                end
                e_next = e_reg + NW'(1);
                state_next = edge_last ? B_POP : B_ERD;
            end
            L_RD:
            begin
                state_next = L_P;
            end
            L_P, L_W:
            begin
                if (state_reg == L_P && tab_rdata != NO_NODE)
                begin
                    state_next = L_W;
                end
                else if (lift_last)
                begin
                    j_next = '0;
                    if (32'(i_reg) == 32'(LEVELS - 1))
                    begin
                        built_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next = i_reg + LW'(1);
                        state_next = L_RD;
                    end
                end
                else
                begin
                    j_next = j_reg + NW'(1);
                    state_next = L_RD;
                end
            end
            Q_MA:
            begin
                state_next = Q_MB;
            end
            Q_MB:
            begin
                ma_next = mark_rdata;
                state_next = Q_MC;
            end
            Q_MC:
            begin
                if (!ma_reg || !mark_rdata)
                begin
                    res_status_next = ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = Q_DA;
                end
            end
            Q_DA:
            begin
                da_next = dep_rdata;
                state_next = Q_DB;
            end
            Q_DB:
            begin
                db_next = dep_rdata;
                if (da_reg < dep_rdata)
                begin
                    qa_next = b_reg;
                    qb_next = a_reg;
                    diff_next = dep_rdata - da_reg;
                end
                else
                begin
                    qa_next = a_reg;
                    qb_next = b_reg;
                    diff_next = da_reg - dep_rdata;
                end
                state_next = Q_UP;
            end
            Q_UP:
            begin
                if (diff_reg == '0)
                begin
                    if (qa_reg == qb_reg)
                    begin
                        lca_next = qa_reg;
                        state_next = Q_LD;
                    end
                    else
                    begin
                        lvl_next = LW'(LEVELS - 1);
                        state_next = Q_HA;
                    end
                end
                else
                begin
                    diff_next = diff_reg - (NW'(1) << up_lvl);
                    state_next = Q_UPW;
                end
            end
            Q_UPW:
            begin
                qa_next = tab_rdata[NW-1:0];
                state_next = Q_UP;
            end
            Q_HA:
            begin
                state_next = Q_HB;
            end
            Q_HB:
            begin
                ha_next = tab_rdata;
                state_next = Q_HC;
            end
            Q_HC:
            begin
                if (ha_reg != tab_rdata)
                begin
                    qa_next = ha_reg[NW-1:0];
                    qb_next = tab_rdata[NW-1:0];
                    state_next = Q_HA;
                end
                else if (lvl_reg == '0)
                begin
                    state_next = Q_LCA;
                end
                else
                begin
                    lvl_next = lvl_reg - LW'(1);
                    state_next = Q_HA;
                end
            end
            Q_LCA:
            begin
                lca_next = tab_rdata[NW-1:0];
                state_next = Q_LD;
            end
            Q_LD:
            begin
                state_next = Q_LDW;
            end
            Q_LDW:
            begin
                res_dist_next = DIST_W'(dist_c);
                ca_next = a_reg;
                lvl_next = '0;
                if ((32'(k_reg) >> LEVELS) != 32'd0)
                begin
                    ca_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = Q_CL;
                end
            end
            Q_CL:
            begin
                if (((32'(k_reg) >> lvl_reg) & 32'd1) != 32'd0)
                begin
                    state_next = Q_CW;
                end
                else if (32'(lvl_reg) == 32'(LEVELS - 1))
                begin
                    res_found_next = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            Q_CW:
            begin
                if (tab_rdata == NO_NODE)
                begin
                    ca_next = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    ca_next = tab_rdata[NW-1:0];
                    if (32'(lvl_reg) == 32'(LEVELS - 1))
                    begin
                        res_found_next = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LW'(1);
                        state_next = Q_CL;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            root_node_reg  <= '0;
            node_count_reg <= COUNT_W'(1024);
            edge_total_reg <= '0;
            built_reg      <= 1'b0;
            sp_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_total_reg <= edge_total_next;
            built_reg      <= built_next;
            sp_reg         <= sp_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_index == CFG_ROOT)
            begin
                root_node_reg <= cfg_data[FIELD_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_COUNT)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg <= e_next;
        j_reg <= j_next;
        i_reg <= i_next;
        lvl_reg <= lvl_next;
        cur_reg <= cur_next;
        cur_dep_reg <= cur_dep_next;
        nb_reg <= nb_next;
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        da_reg <= da_next;
        db_reg <= db_next;
        diff_reg <= diff_next;
        ha_reg <= ha_next;
        ma_reg <= ma_next;
        lca_reg <= lca_next;
        ca_reg <= ca_next;
        res_status_reg <= res_status_next;
        res_dist_reg <= res_dist_next;
        res_found_reg <= res_found_next;
        out_data_reg <= out_data_next;
    end

    taqe_ram #(.WIDTH(2*NW), .DEPTH(MAX_NODES - 1)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(EAW'(edge_waddr)),
        .wdata(edge_wdata), .raddr(EAW'(edge_raddr)),
        .rdata(edge_rdata)
    );

    taqe_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark_ram (
        .clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
        .raddr(mark_raddr), .rdata(mark_rdata)
    );

    taqe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_depth_ram (
        .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
        .raddr(dep_raddr), .rdata(dep_rdata)
    );

    taqe_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_stack_ram (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    taqe_ram #(.WIDTH(TEW), .DEPTH(TD)) u_table_ram (
        .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
        .raddr(tab_raddr), .rdata(tab_rdata)
    );

    a_built_from_lift: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(built_reg) |-> ($past(state_reg) == L_P || $past(state_reg) == L_W))
        else $error("tables marked built outside the lifting pass");

    a_edge_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (edge_total_reg != $past(edge_total_reg)) |->
            (edge_total_reg == $past(edge_total_reg) + NW'(1)))
        else $error("edge count moved by other than one");

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(sp_reg) <= 32'(MAX_NODES))
        else $error("walk stack overflow");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(m_tready))
        else $error("result dropped without being taken");

endmodule

`default_nettype wire

>>> sim/taqe_checker.sv
// ---------------------------------------------------------------------------
// taqe_checker
// Watches the request, result and configuration channels of the tree
// ancestor query engine. It keeps its own copy of the edge store and of the
// lifting table, predicts one result for every accepted request, and compares
// each accepted result field by field with the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module taqe_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [taqe_pkg::IN_W-1:0]       s_tdata,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [taqe_pkg::OUT_W-1:0]      m_tdata,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [taqe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [taqe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   failures,
    output int                                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import taqe_pkg::*;

    localparam int NODES = 1024;
    localparam int LV    = 11;
    localparam logic [10:0] NONE = 11'd1024;

    typedef struct packed {
        status_t     status;
        logic [9:0]  lca;
        logic [10:0] path_len;
        logic [9:0]  anc;
        logic        found;
    } result_t;

    logic [9:0]  edge_lo [NODES-1];
    logic [9:0]  edge_hi [NODES-1];
    int unsigned edges_held;
    logic [10:0] lift [NODES][LV];
    logic [9:0]  depth_of [NODES];
    bit          reached [NODES];
    bit          built;
    logic [9:0]  root_sel;
    logic [10:0] count_sel;
    result_t     expected_q [$];

    assign pending = expected_q.size();

    function automatic int unsigned live_nodes();
        return (count_sel > NODES) ? NODES : count_sel;
    endfunction

    function automatic status_t build_lift();
        int unsigned cnt;
        int unsigned sp;
        int unsigned cur;
        int unsigned nb;
        int unsigned walk [NODES];
        cnt = live_nodes();
        built = 0;
        if (root_sel >= cnt)
            return ST_RANGE;
        for (int n = 0; n < NODES; n++)
        begin
            reached[n] = 0;
            depth_of[n] = '0;
            for (int l = 0; l < LV; l++)
                lift[n][l] = NONE;
        end
        reached[root_sel] = 1;
        sp = 0;
        walk[sp] = root_sel;
        sp = sp + 1;
        while (sp > 0)
        begin
            sp = sp - 1;
            cur = walk[sp];
            for (int e = 0; e < edges_held; e++)
            begin
                if (edge_lo[e] == cur)
                    nb = edge_hi[e];
                else if (edge_hi[e] == cur)
                    nb = edge_lo[e];
                else
                    continue;
                if (nb >= cnt || reached[nb])
                    continue;
                reached[nb] = 1;
                lift[nb][0] = cur;
                depth_of[nb] = depth_of[cur] + 10'd1;
                if (sp < NODES)
                begin
                    walk[sp] = nb;
                    sp = sp + 1;
                end
            end
        end
        for (int l = 1; l < LV; l++)
            for (int j = 0; j < cnt; j++)
                if (lift[j][l-1] != NONE)
                    lift[j][l] = lift[lift[j][l-1]][l-1];
        built = 1;
        return ST_OK;
    endfunction

    function automatic logic [9:0] meet(input logic [9:0] a, input logic [9:0] b);
        int unsigned x;
        int unsigned y;
        int unsigned t;
        int unsigned diff;
        int lvl;
        x = a;
        y = b;
        if (depth_of[x] < depth_of[y])
        begin
            t = x;
            x = y;
            y = t;
        end
        diff = depth_of[x] - depth_of[y];
        lvl = LV - 1;
        while (diff != 0)
        begin
            while ((1 << lvl) > diff)
                lvl--;
            x = lift[x][lvl];
            diff -= (1 << lvl);
        end
        if (x == y)
            return x[9:0];
        for (int l = LV - 1; l >= 0; l--)
            while (lift[x][l] != lift[y][l])
            begin
                x = lift[x][l];
                y = lift[y][l];
            end
        return lift[x][0][9:0];
    endfunction

    function automatic logic [10:0] climb_up(input logic [9:0] u, input logic [9:0] k);
        logic [10:0] n;
        n = u;
        for (int l = 0; l < LV; l++)
            if (l < 10 && k[l])
            begin
                n = lift[n][l];
                if (n == NONE)
                    break;
            end
        return n;
    endfunction

    function automatic result_t predict(input op_t op, input logic [9:0] a,
                                        input logic [9:0] b, input logic [9:0] k);
        result_t r;
        int unsigned cnt;
        logic [10:0] up;
        r = '0;
        cnt = live_nodes();
        if (op == OP_ADD)
        begin
            if (a >= cnt || b >= cnt)
                r.status = ST_RANGE;
            else if (edges_held >= NODES - 1)
                r.status = ST_FULL;
            else
            begin
                edge_lo[edges_held] = a;
                edge_hi[edges_held] = b;
                edges_held++;
                built = 0;
            end
        end
        else if (op == OP_BUILD)
            r.status = build_lift();
        else if (op == OP_QUERY)
        begin
            if (a >= cnt || b >= cnt)
                r.status = ST_RANGE;
            else if (!built)
                r.status = ST_NOTBUILT;
            else if (!reached[a] || !reached[b])
                r.status = ST_RANGE;
            else
            begin
                r.lca = meet(a, b);
                r.path_len = 11'(depth_of[a]) + 11'(depth_of[b])
                             - 11'(2 * depth_of[r.lca]);
                up = climb_up(a, k);
                if (up != NONE)
                begin
                    r.anc = up[9:0];
                    r.found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            failures <= 0;
            expected_q.delete();
            edges_held = 0;
            built = 0;
            root_sel = '0;
            count_sel = 11'd1024;
            for (int n = 0; n < NODES; n++)
                reached[n] = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status   = m_tdata[1:0];
                got.lca      = m_tdata[11:2];
                got.path_len = m_tdata[22:12];
                got.anc      = m_tdata[32:23];
                got.found    = m_tdata[33];
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $realtime, m_tdata);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got != want)
                    begin
                        $display({"%0t: mismatch status %0d/%0d lca %0d/%0d",
                                  " distance %0d/%0d anc %0d/%0d found %0d/%0d",
                                  " (expected/actual)"},
                                 $realtime, want.status, got.status, want.lca, got.lca,
                                 want.path_len, got.path_len, want.anc, got.anc,
                                 want.found, got.found);
                        failures <= failures + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_ROOT)
                    root_sel = cfg_data[9:0];
                else if (cfg_index == CFG_COUNT)
                    count_sel = cfg_data;
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict(s_tdata[1:0], s_tdata[11:2],
                                             s_tdata[21:12], s_tdata[31:22]));
        end
    end

endmodule

`default_nettype wire

>>> sim/tb_tree_ancestor_query_engine_unit.sv
// ---------------------------------------------------------------------------
// tb_tree_ancestor_query_engine_unit
// Drives the tree ancestor query engine with directed and random requests.
// Trees are loaded edge by edge under several root and node count settings,
// built, and queried; the checker predicts and compares every result. The
// run ends with a short burst of back-to-back requests without any idling.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_tree_ancestor_query_engine_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import taqe_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    failures;
    int                    pending;
    bit                    idle_en;

    tree_ancestor_query_engine_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    taqe_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #60_000_000;
        $display("FAIL tree_ancestor_query_engine_unit");
        $finish;
    end

    initial
    begin
        m_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (idle_en && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    task automatic send_request(input op_t op, input int a, input int b, input int k);
        if (idle_en && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {k[9:0], b[9:0], a[9:0], op};
        @(posedge clk iff s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk iff cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic tree_phase(input int count, input int root, input int n_edges,
                              input int n_queries);
        int members [$];
        int a;
        int b;
        int k;
        drain();
        write_reg(CFG_COUNT, count);
        write_reg(CFG_ROOT, root);
        members.push_back(root);
        for (int i = 0; i < n_edges; i++)
        begin
            a = $urandom_range(0, count - 1);
            b = members[$urandom_range(0, members.size() - 1)];
            if ($urandom_range(0, 7) == 0)
                send_request(OP_ADD, $urandom_range(0, 1023), b, 0);
            else
            begin
                send_request(OP_ADD, a, b, 0);
                members.push_back(a);
            end
        end
        send_request(OP_QUERY, root, root, 0);
        send_request(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
        for (int i = 0; i < n_queries; i++)
        begin
            a = members[$urandom_range(0, members.size() - 1)];
            b = members[$urandom_range(0, members.size() - 1)];
            k = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 12)
                                            : $urandom_range(0, 1023);
            case ($urandom_range(0, 9))
                0: send_request(OP_QUERY, $urandom_range(0, 1023), b, k);
                1: send_request(OP_NOP, $urandom_range(0, 1023), $urandom_range(0, 1023), k);
                default: send_request(OP_QUERY, a, b, k);
            endcase
        end
    endtask

    initial
    begin
        int count;
        idle_en   = 1'b1;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_QUERY, 1, 2, 3);
        send_request(OP_NOP, 1023, 1023, 1023);
        send_request(OP_BUILD, 0, 0, 0);
        drain();
        write_reg(CFG_COUNT, 16);
        send_request(OP_ADD, 0, 20, 0);
        send_request(OP_ADD, 0, 1, 0);
        send_request(OP_ADD, 1, 2, 0);
        send_request(OP_ADD, 2, 3, 0);
        send_request(OP_ADD, 0, 4, 0);
        send_request(OP_ADD, 4, 5, 0);
        send_request(OP_ADD, 5, 5, 0);
        send_request(OP_ADD, 1, 0, 0);
        send_request(OP_ADD, 3, 6, 0);
        send_request(OP_ADD, 6, 7, 0);
        send_request(OP_ADD, 7, 2, 0);
        send_request(OP_QUERY, 3, 7, 1);
        send_request(OP_BUILD, 0, 0, 0);
        send_request(OP_QUERY, 7, 5, 0);
        send_request(OP_QUERY, 7, 7, 1023);
        send_request(OP_QUERY, 6, 4, 4);
        send_request(OP_QUERY, 15, 3, 1);
        send_request(OP_QUERY, 1023, 0, 1);
        drain();
        write_reg(CFG_ROOT, 20);
        send_request(OP_BUILD, 0, 0, 0);
        send_request(OP_QUERY, 1, 2, 1);

        tree_phase(1024, 1023, 12, 55);
        tree_phase(40, 7, 12, 55);
        tree_phase(1024, 500, 12, 55);
        tree_phase(1, 0, 4, 20);
        tree_phase(300, 299, 12, 55);
        tree_phase(64, 0, 12, 55);
        tree_phase(1024, 0, 12, 55);
        tree_phase(200, 100, 12, 55);

        drain();
        idle_en = 1'b0;
        write_reg(CFG_COUNT, 2);
        write_reg(CFG_ROOT, 1);
        for (int i = 0; i < 40; i++)
            send_request(OP_ADD, i % 2, (i + 1) % 2, 0);
        send_request(OP_BUILD, 0, 0, 0);
        for (int i = 0; i < 8; i++)
            send_request(OP_QUERY, i % 2, (i / 2) % 2, i);
        s_tvalid <= 1'b0;

        count = 0;
        @(posedge clk);
        while (pending != 0 && count < 200000)
        begin
            @(posedge clk);
            count++;
        end
        repeat (200) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("PASS tree_ancestor_query_engine_unit");
        else
            $display("FAIL tree_ancestor_query_engine_unit");
        $finish;
    end

endmodule

`default_nettype wire
